// ===== design/sbpr_pkg.sv =====
package sbpr_pkg;

	localparam int STORE_DEPTH = 256;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	localparam logic [7:0] HDR_BYTE   = 8'hFF;
	localparam logic [7:0] MIN_LENGTH = 8'd2;

	localparam int OBUF_DEPTH = 3;
	localparam int OBUF_PTR_W = 2;
	localparam int OBUF_CNT_W = 2;

	typedef enum logic [2:0] {
		PH_HDR1  = 3'd0,
		PH_HDR2  = 3'd1,
		PH_ID    = 3'd2,
		PH_LEN   = 3'd3,
		PH_INSTR = 3'd4,
		PH_BODY  = 3'd5
	} phase_t;

	typedef enum logic {
		KIND_PACKET = 1'b0,
		KIND_READ   = 1'b1
	} result_kind_t;

	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_READ = 1'b1
	} command_t;

	localparam logic [1:0] ST_GOOD     = 2'd0;
	localparam logic [1:0] ST_CHECKSUM = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [1:0] status;
		logic [7:0] instruction;
		logic [7:0] count;
		logic [7:0] data;
	} out_beat_t;

endpackage

// ===== design/sbpr_out_buf.sv =====
module sbpr_out_buf (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  sbpr_pkg::out_beat_t             push_beat,
	input  logic                            pop,
	output sbpr_pkg::out_beat_t             head_beat,
	output logic                            head_valid,
	output logic [sbpr_pkg::OBUF_CNT_W-1:0] fill
);
	import sbpr_pkg::*;

	out_beat_t               entries_q [OBUF_DEPTH];
	logic [OBUF_PTR_W-1:0]   wr_ptr_q;
	logic [OBUF_PTR_W-1:0]   rd_ptr_q;
	logic [OBUF_CNT_W-1:0]   cnt_q;
	logic                    do_pop;

	assign head_valid = (cnt_q != '0);
	assign head_beat  = entries_q[rd_ptr_q];
	assign fill       = cnt_q;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == OBUF_PTR_W'(OBUF_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == OBUF_PTR_W'(OBUF_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/servo_bus_packet_receiver_top.sv =====
// An accepted item's result beat is registered in stage s1, then pushed into the output buffer.
// Throughput: one item per cycle unless stalled; the parameter store is one write port and one
// registered read port, and a 3-beat output buffer takes results while out_stall is high.
// in_stall is driven from registers only (buffer fill plus the beat in flight).
// Reset clears the parser to header hunting and own_id to 1; the parameter store is not cleared.
module servo_bus_packet_receiver_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       command,
	input  logic [7:0] rx_byte,
	input  logic [7:0] read_index,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       result_kind,
	output logic [1:0] status,
	output logic [7:0] instruction_code,
	output logic [7:0] param_count,
	output logic [7:0] read_data
);
	import sbpr_pkg::*;

	logic [7:0] own_id_q;

	phase_t     phase_q, phase_d;
	logic [7:0] remain_q, remain_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] instr_q, instr_d;
	logic [7:0] count_q, count_d;
	logic       ovf_q, ovf_d;

	logic       accept;
	logic       is_read;
	logic       is_byte;
	logic [7:0] remain_dec;
	logic [7:0] pos;
	logic       pos_ok;
	logic       mem_we;
	logic       pkt_done;
	logic [1:0] pkt_status;

	logic [7:0] store_mem [STORE_DEPTH];
	logic [7:0] rdata_s1;

	logic       valid_s1;
	logic       kind_s1;
	logic [1:0] status_s1;
	logic [7:0] instr_s1;
	logic [7:0] count_s1;
	logic       oob_s1;

	out_beat_t             beat_s1;
	out_beat_t             head_beat;
	logic [OBUF_CNT_W-1:0] fill;
	logic [OBUF_CNT_W:0]   pending;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			own_id_q <= cfg_data;
		end
	end

	assign pending  = {1'b0, fill} + {{OBUF_CNT_W{1'b0}}, valid_s1};
	assign in_stall = (pending >= (OBUF_CNT_W + 1)'(OBUF_DEPTH));
	assign accept   = in_valid && !in_stall;
	assign is_read  = accept && (command == CMD_READ);
	assign is_byte  = accept && (command == CMD_BYTE);

	assign remain_dec = remain_q - 8'd1;
	assign pos        = count_q - remain_dec;
	assign pos_ok     = ({1'b0, pos} < 9'(STORE_DEPTH));

	always_comb begin
		phase_d    = phase_q;
		remain_d   = remain_q;
		sum_d      = sum_q;
		instr_d    = instr_q;
		count_d    = count_q;
		ovf_d      = ovf_q;
		mem_we     = 1'b0;
		pkt_done   = 1'b0;
		pkt_status = ST_GOOD;
		case (phase_q)
			PH_HDR2: begin
				phase_d = (rx_byte == HDR_BYTE) ? PH_ID : PH_HDR1;
			end
			PH_ID: begin
				if (rx_byte != HDR_BYTE) begin
					sum_d   = rx_byte;
					instr_d = '0;
					count_d = '0;
					ovf_d   = 1'b0;
					phase_d = (rx_byte == own_id_q) ? PH_LEN : PH_HDR1;
				end
			end
			PH_LEN: begin
				if (rx_byte < MIN_LENGTH) begin
					phase_d = PH_HDR1;
				end else begin
					remain_d = rx_byte;
					count_d  = rx_byte - MIN_LENGTH;
					sum_d    = sum_q + rx_byte;
					phase_d  = PH_INSTR;
				end
			end
			PH_INSTR: begin
				instr_d  = rx_byte;
				sum_d    = sum_q + rx_byte;
				remain_d = remain_dec;
				phase_d  = PH_BODY;
			end
			PH_BODY: begin
				remain_d = remain_dec;
				if (remain_dec != '0) begin
					if (pos_ok) begin
						mem_we = 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
					sum_d = sum_q + rx_byte;
				end else begin
					pkt_done = 1'b1;
					if (rx_byte != ~sum_q) begin
						pkt_status = ST_CHECKSUM;
					end else if (ovf_q) begin
						pkt_status = ST_OVERFLOW;
					end
					phase_d = PH_HDR1;
				end
			end
			default: begin
				phase_d = (rx_byte == HDR_BYTE) ? PH_HDR2 : PH_HDR1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR1;
			remain_q <= '0;
			sum_q    <= '0;
			instr_q  <= '0;
			count_q  <= '0;
			ovf_q    <= 1'b0;
		end else if (is_byte) begin
			phase_q  <= phase_d;
			remain_q <= remain_d;
			sum_q    <= sum_d;
			instr_q  <= instr_d;
			count_q  <= count_d;
			ovf_q    <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		if (is_byte && mem_we) begin
			store_mem[pos[ADDR_W-1:0]] <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (is_read) begin
			rdata_s1 <= store_mem[read_index[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= is_read || (is_byte && pkt_done);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= is_read ? KIND_READ : KIND_PACKET;
			status_s1 <= pkt_status;
			instr_s1  <= (pkt_status == ST_GOOD) ? instr_q : '0;
			count_s1  <= (pkt_status == ST_GOOD) ? count_q : '0;
			oob_s1    <= !({1'b0, read_index} < 9'(STORE_DEPTH));
		end
	end

	always_comb begin
		beat_s1.kind        = kind_s1;
		beat_s1.status      = (kind_s1 == KIND_READ) ? ST_GOOD : status_s1;
		beat_s1.instruction = (kind_s1 == KIND_READ) ? 8'd0 : instr_s1;
		beat_s1.count       = (kind_s1 == KIND_READ) ? 8'd0 : count_s1;
		beat_s1.data        = ((kind_s1 == KIND_READ) && !oob_s1) ? rdata_s1 : 8'd0;
	end

	sbpr_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (valid_s1),
		.push_beat  (beat_s1),
		.pop        (!out_stall),
		.head_beat  (head_beat),
		.head_valid (out_valid),
		.fill       (fill)
	);

	assign result_kind      = head_beat.kind;
	assign status           = head_beat.status;
	assign instruction_code = head_beat.instruction;
	assign param_count      = head_beat.count;
	assign read_data        = head_beat.data;

endmodule
